// ===== rtl/core/clru_pkg.sv =====
// Shared types and constants of the counter-based LRU replacement block.
`timescale 1ns / 1ps

package clru_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int ADDR_W      = 32;
  localparam int WAY_W       = 2;
  localparam int MASK_W      = 4;
  localparam int OFFSET_W    = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Block offset after reset: 64-byte blocks.
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd6;

  // Number of items held between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Command carried in tuser.
  typedef enum logic {
    CMD_VICTIM = 1'b0,
    CMD_TOUCH  = 1'b1
  } cmd_e;

  // Set-independent part of a classified item.
  typedef struct packed {
    cmd_e              cmd;
    logic [WAY_W-1:0]  way;
    logic [MASK_W-1:0] mask;
  } item_t;

endpackage

// ===== rtl/core/counter_lru_replacement.sv =====
// Path: an item passes through the queue, the registered age-row read and the output register.
// Flow: the back end takes a new item only once the previous one has left its calculation
// state, so a touch's age row is written back before the next read.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the age memory row
// by row, during which no item is taken; configuration writes are taken throughout.
`timescale 1ns / 1ps

module counter_lru_replacement #(
  parameter int NUM_SETS = 64,
  parameter int WAYS     = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Block offset register write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [clru_pkg::OFFSET_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: address[31:0], touched_way[33:32], valid_mask[37:34], zeros.
  input  logic [clru_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic                              s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: victim_way[1:0], victim_was_free[2], zeros.
  output logic [clru_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int IW = $bits(clru_pkg::item_t);

  logic              clear_busy;
  logic              push_valid;
  logic              push_ready;
  logic [SW-1:0]     push_set;
  clru_pkg::item_t   push_item;
  logic              pop_valid;
  logic              pop;
  logic [SW+IW-1:0]  pop_data;
  clru_pkg::item_t   pop_item;

  // Front: configuration and set index.
  clru_front #(
    .NUM_SETS (NUM_SETS),
    .SW       (SW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clear_busy_i  (clear_busy),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_set_o    (push_set),
    .push_item_o   (push_item)
  );

  // Queue between the two halves.
  clru_queue #(
    .WIDTH (SW + IW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_set, push_item}),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  assign pop_item = clru_pkg::item_t'(pop_data[IW-1:0]);

  // Back: age memory and results.
  clru_back #(
    .NUM_SETS (NUM_SETS),
    .WAYS     (WAYS),
    .SW       (SW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_busy_o  (clear_busy),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .pop_set_i     (pop_data[SW+IW-1:IW]),
    .pop_item_i    (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/clru_front.sv =====
// Front end: holds the block offset register, accepts items and works out their set index.
`timescale 1ns / 1ps

module clru_front #(
  parameter int NUM_SETS = 64,
  parameter int SW       = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [clru_pkg::OFFSET_W-1:0]      cfg_data_i,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [clru_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tuser,
  // Back end busy with the clearing pass.
  input  logic                               clear_busy_i,
  // Push side of the queue.
  output logic                               push_valid_o,
  input  logic                               push_ready_i,
  output logic [SW-1:0]                      push_set_o,
  output clru_pkg::item_t                    push_item_o
);

  localparam logic [SW-1:0] SET_MASK = SW'(NUM_SETS - 1);

  logic [clru_pkg::OFFSET_W-1:0] offset_q;
  logic [clru_pkg::ADDR_W-1:0]   address;
  logic [clru_pkg::ADDR_W-1:0]   block_num;

  // The block offset register takes every write transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= clru_pkg::OFFSET_RESET;
    end else if (cfg_valid_i) begin
      offset_q <= cfg_data_i;
    end
  end

  // Unpack the item and derive the set from the block number.
  assign address   = s_axis_tdata[clru_pkg::ADDR_W-1:0];
  assign block_num = address >> offset_q;
  assign push_set_o = block_num[SW-1:0] & SET_MASK;

  assign push_item_o.cmd  = clru_pkg::cmd_e'(s_axis_tuser);
  assign push_item_o.way  = s_axis_tdata[clru_pkg::ADDR_W +: clru_pkg::WAY_W];
  assign push_item_o.mask = s_axis_tdata[clru_pkg::ADDR_W + clru_pkg::WAY_W +: clru_pkg::MASK_W];

  // No transfer is taken while the age memory is being cleared.
  assign push_valid_o  = s_axis_tvalid && !clear_busy_i;
  assign s_axis_tready = push_ready_i && !clear_busy_i;

endmodule

// ===== rtl/core/clru_queue.sv =====
// Short first-in first-out queue between the front and the back end.
`timescale 1ns / 1ps

module clru_queue #(
  parameter int WIDTH = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int DEPTH = clru_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;

  // Storage: written at the write pointer only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/clru_back.sv =====
// Back end: age memory, victim choice, age update and the output register.
`timescale 1ns / 1ps

module clru_back #(
  parameter int NUM_SETS = 64,
  parameter int WAYS     = 4,
  parameter int SW       = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  output logic                               clear_busy_o,
  // Pop side of the queue.
  input  logic                               pop_valid_i,
  output logic                               pop_o,
  input  logic [SW-1:0]                      pop_set_i,
  input  clru_pkg::item_t                    pop_item_i,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [clru_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int AW = $clog2(WAYS);
  localparam int VW = $clog2(WAYS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC
  } state_e;

  typedef logic [WAYS-1:0][AW-1:0] row_t;

  state_e                      state_q;
  logic [SW-1:0]               clr_idx_q;
  logic [SW-1:0]               set_q;
  clru_pkg::item_t             item_q;
  row_t                        mem_q [NUM_SETS];
  row_t                        row_q;
  row_t                        new_row;
  logic                        out_valid_q;
  logic [clru_pkg::WAY_W-1:0]  out_way_q;
  logic                        out_free_q;
  logic                        slot_free;
  logic                        start;
  logic                        touch_write;
  logic [WAYS+clru_pkg::MASK_W-1:0] valid_ext;
  logic [clru_pkg::WAY_W-1:0]  victim;
  logic                        found_free;
  logic                        found_old;
  logic [VW-1:0]               way_idx;
  logic                        way_in_range;
  logic [AW-1:0]               ref_age;

  // An item starts only when its result is sure to find the output register free.
  assign slot_free    = !out_valid_q || m_axis_tready;
  assign start        = (state_q == S_IDLE) && pop_valid_i && slot_free;
  assign pop_o        = start;
  assign clear_busy_o = (state_q == S_CLEAR);

  // Victim choice: first invalid way, else first way of age zero, else way zero.
  // Ways without a bit in the valid mask count as valid.
  assign valid_ext = {{WAYS{1'b1}}, item_q.mask};

  always_comb begin
    victim     = '0;
    found_free = 1'b0;
    found_old  = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found_free && !valid_ext[i]) begin
        victim     = clru_pkg::WAY_W'(i);
        found_free = 1'b1;
      end
    end
    if (!found_free) begin
      for (int i = 0; i < WAYS; i++) begin
        if (!found_old && (row_q[i] == '0)) begin
          victim    = clru_pkg::WAY_W'(i);
          found_old = 1'b1;
        end
      end
    end
  end

  // Touch: ages above the touched way's age drop by one, the touched way becomes newest.
  assign way_idx      = VW'(item_q.way);
  assign way_in_range = (32'(item_q.way) < WAYS);
  assign ref_age      = row_q[way_idx];
  assign touch_write  = (state_q == S_CALC) && (item_q.cmd == clru_pkg::CMD_TOUCH) &&
                        way_in_range;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (VW'(i) == way_idx) begin
        new_row[i] = AW'(WAYS - 1);
      end else if (row_q[i] > ref_age) begin
        new_row[i] = row_q[i] - 1'b1;
      end else begin
        new_row[i] = row_q[i];
      end
    end
  end

  // Age memory: cleared row by row after reset, read when an item starts,
  // written back in the next cycle for a touch.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      mem_q[clr_idx_q] <= '0;
    end else if (touch_write) begin
      mem_q[set_q] <= new_row;
    end
    if (start) begin
      row_q <= mem_q[pop_set_i];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      set_q       <= '0;
      item_q      <= '0;
      out_valid_q <= 1'b0;
      out_way_q   <= '0;
      out_free_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (clr_idx_q == SW'(NUM_SETS - 1)) begin
            state_q <= S_IDLE;
          end else begin
            clr_idx_q <= clr_idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            set_q   <= pop_set_i;
            item_q  <= pop_item_i;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          out_valid_q <= 1'b1;
          if (item_q.cmd == clru_pkg::CMD_VICTIM) begin
            out_way_q  <= victim;
            out_free_q <= found_free;
          end else begin
            out_way_q  <= '0;
            out_free_q <= 1'b0;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(clru_pkg::OUT_TDATA_W - clru_pkg::WAY_W - 1){1'b0}},
                          out_free_q, out_way_q};

endmodule
